[sv/swr_pkg.sv]
package swr_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Word returned by a pop or peek on an empty stack.
  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    logic               is_push;
    logic               is_read;
    logic               is_pop;
    logic               is_remove;
    logic signed [31:0] value;
  } cmd_t;

endpackage

[sv/swr_ifs.sv]
// Request channel: one word per request.
interface swr_req_if import swr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink (input valid, input opcode, input operand_value, output ready);
endinterface

// Response channel: one word per request.
interface swr_rsp_if import swr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  logic [1:0]         status;
  logic [4:0]         fill_count;

  modport source (output valid, output read_data, output status, output fill_count,
                  input ready);
  modport sink (input valid, input read_data, input status, input fill_count,
                output ready);
endinterface

[sv/swr_front.sv]
module swr_front import swr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  swr_req_if.sink    req,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  // Turn an opcode into the flags the back acts on.
  function automatic cmd_t classify(logic [1:0] op, logic signed [31:0] val);
    cmd_t c;
    c.is_push   = 1'b0;
    c.is_read   = 1'b0;
    c.is_pop    = 1'b0;
    c.is_remove = 1'b0;
    c.value     = val;
    case (op)
      OP_PUSH:   c.is_push = 1'b1;
      OP_POP: begin
        c.is_read = 1'b1;
        c.is_pop  = 1'b1;
      end
      OP_PEEK:   c.is_read = 1'b1;
      OP_REMOVE: c.is_remove = 1'b1;
      default:   c.is_remove = 1'b1;
    endcase
    return c;
  endfunction

  // Two-entry queue of classified requests.
  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign req.ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rptr];
  assign do_wr     = req.valid && req.ready;
  assign do_rd     = cmd_valid && cmd_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) slot[wptr] <= classify(req.opcode, req.operand_value);
  end

endmodule

[sv/swr_back.sv]
module swr_back import swr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  swr_rsp_if.source  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SCMP = 5'b00100,
    S_HRD  = 5'b01000,
    S_HWR  = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic               cur_pop, cur_pop_next;
  logic signed [31:0] cur_value, cur_value_next;

  logic [CW-1:0]      count_dec;
  logic [CW-1:0]      ptr_dec;
  logic [CW-1:0]      ptr_inc;

  // Entry memory, index 0 at the bottom.
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;

  // Result register.
  logic               out_valid;
  logic signed [31:0] out_rd;
  logic [1:0]         out_st;
  logic [4:0]         out_fill;
  logic               res_load;
  logic signed [31:0] res_rd;
  logic [1:0]         res_st;

  assign count_dec = count - 1'b1;
  assign ptr_dec   = ptr - 1'b1;
  assign ptr_inc   = ptr + 1'b1;
  assign cmd_ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  // Sequencer: one request at a time, searching and closing gaps an entry a step.
  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    cur_pop_next   = cur_pop;
    cur_value_next = cur_value;
    mem_we         = 1'b0;
    mem_waddr      = ptr[AW-1:0];
    mem_wdata      = rd_q;
    mem_raddr      = ptr[AW-1:0];
    res_load       = 1'b0;
    res_rd         = 32'sd0;
    res_st         = STAT_OK;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          cur_pop_next   = cmd.is_pop;
          cur_value_next = cmd.value;
          if (cmd.is_push) begin
            res_load = 1'b1;
            if (count == FULL_COUNT) begin
              res_st = STAT_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = cmd.value;
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            // Empty stack: reads report empty, a remove finds nothing.
            res_load = 1'b1;
            if (cmd.is_remove) begin
              res_st = STAT_NOT_FOUND;
            end else begin
              res_rd = EMPTY_WORD;
              res_st = STAT_EMPTY;
            end
          end else begin
            mem_raddr = count_dec[AW-1:0];
            ptr_next  = count_dec;
            state_next = cmd.is_read ? S_READ : S_SCMP;
          end
        end
      end
      S_READ: begin
        res_load = 1'b1;
        res_rd   = rd_q;
        if (cur_pop) count_next = count_dec;
        state_next = S_IDLE;
      end
      S_SCMP: begin
        // The word at ptr is in rd_q; on a miss fetch the one below.
        if (rd_q == cur_value) begin
          state_next = S_HRD;
        end else if (ptr == '0) begin
          res_load   = 1'b1;
          res_st     = STAT_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          mem_raddr = ptr_dec[AW-1:0];
          ptr_next  = ptr_dec;
        end
      end
      S_HRD: begin
        if (ptr_inc < count) begin
          mem_raddr  = ptr_inc[AW-1:0];
          state_next = S_HWR;
        end else begin
          count_next = count_dec;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HWR: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr[AW-1:0];
        mem_wdata  = rd_q;
        ptr_next   = ptr_inc;
        state_next = S_HRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    cur_pop   <= cur_pop_next;
    cur_value <= cur_value_next;
  end

  // Memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // Result register; a result is loaded only when the slot is free or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_rd   <= res_rd;
      out_st   <= res_st;
      out_fill <= 5'(count_next);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_rd;
  assign rsp.status     = out_st;
  assign rsp.fill_count = out_fill;

endmodule

[sv/stack_with_remove_by_value.sv]
// Push, and any request on an empty stack, go straight to the result register; pop and
// peek first read the top entry; remove searches down from the top an entry a step, and
// on a match moves each entry above the match down one place.
// The back carries out one request at a time; a two-word queue keeps taking requests
// while a result waits.
// Reset (synchronous): the stack empties and the queue clears; entries are not cleared.
module stack_with_remove_by_value import swr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  swr_req_if.sink    req,
  swr_rsp_if.source  rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: accepts and classifies requests into a short queue.
  swr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: holds the stack and carries out each request.
  swr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule
